// ===== design/rkxd_pkg.sv =====
// ----------------------------------------------------------------------------
// rkxd_pkg
// Types, constants and the key update used by the rolling key descrambler.
// ----------------------------------------------------------------------------
package rkxd_pkg;

   localparam int unsigned KEY_BYTES   = 16;
   localparam int unsigned OFF_W       = $clog2(KEY_BYTES);
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   typedef logic [7:0]                  byte_type;
   typedef logic [OFF_W-1:0]            offset_type;
   typedef logic [KEY_BYTES-1:0][7:0]   key_type;
   typedef logic [CSR_INDEX_W-1:0]      csr_index_type;

   // register indexes of the configuration port
   localparam csr_index_type CSR_KEY_LOW  = 2'd0;
   localparam csr_index_type CSR_KEY_HIGH = 2'd1;
   localparam csr_index_type CSR_ENABLE   = 2'd2;

   // the mutator is captured at this offset, the key evolves after the last
   localparam offset_type MUTATOR_OFFSET = offset_type'(KEY_BYTES - 2);
   localparam offset_type LAST_OFFSET    = offset_type'(KEY_BYTES - 1);

   localparam byte_type ADD_M0_K3 = 8'd2;
   localparam byte_type ADD_M0_K4 = 8'd11;
   localparam byte_type ADD_M0_K8 = 8'd7;
   localparam byte_type ADD_M4_K0 = 8'd111;
   localparam byte_type ADD_M4_K3 = 8'd71;
   localparam byte_type ADD_M4_K4 = 8'd17;
   localparam byte_type ADD_M4_KE = 8'd64;

   // Key update after a full block. Assignments run in order, so later
   // ones see bytes already rewritten above them.
   function automatic key_type evolve_key(input key_type key, input byte_type mut);
      key_type k;
      k = key;
      case (mut[2:0])
         3'd0: begin
            k[0]  = k[0] + mut;
            k[3]  = k[3] + mut + ADD_M0_K3;
            k[4]  = k[2] + mut + ADD_M0_K4;
            k[8]  = k[6] + ADD_M0_K8;
         end
         3'd1: begin
            k[2]  = k[9] + k[10];
            k[6]  = k[7] + k[15];
            k[8]  = k[8] + k[1];
            k[15] = k[5] + k[3];
         end
         3'd2: begin
            k[1]  = k[1] + k[2];
            k[5]  = k[5] + k[6];
            k[7]  = k[7] + k[8];
            k[10] = k[10] + k[11];
         end
         3'd3: begin
            k[9]  = k[2] + k[1];
            k[11] = k[6] + k[5];
            k[12] = k[8] + k[7];
            k[13] = k[11] + k[10];
         end
         3'd4: begin
            k[0]  = k[1] + ADD_M4_K0;
            k[3]  = k[4] + ADD_M4_K3;
            k[4]  = k[5] + ADD_M4_K4;
            k[14] = k[15] + ADD_M4_KE;
         end
         3'd5: begin
            k[2]  = k[2] + k[10];
            k[4]  = k[5] + k[12];
            k[6]  = k[8] + k[14];
            k[8]  = k[11] + k[0];
         end
         3'd6: begin
            // own four updates, then the same four as selection seven
            k[9]  = k[11] + k[1];
            k[11] = k[13] + k[3];
            k[13] = k[15] + k[5];
            k[15] = k[9] + k[7];
            k[1]  = k[9] + k[5];
            k[2]  = k[10] + k[6];
            k[3]  = k[11] + k[7];
            k[4]  = k[12] + k[8];
         end
         default: begin
            k[1]  = k[9] + k[5];
            k[2]  = k[10] + k[6];
            k[3]  = k[11] + k[7];
            k[4]  = k[12] + k[8];
         end
      endcase
      return k;
   endfunction

endpackage

// ===== design/rolling_key_xor_descrambler.sv =====
// ----------------------------------------------------------------------------
// rolling_key_xor_descrambler
// Byte stream descrambler: XOR with a 16-byte key that evolves per block, when enabled.
// ----------------------------------------------------------------------------
// Pipeline: a req word is registered in the input stage, then in the result
// stage, which drives rsp_tvalid; a low rsp_tready can hold it in between.
// Throughput: one word per cycle while rsp_tready is high; the key update (a
// few chained 8-bit adds) feeds the key register, not the result register.
// Reset: synchronous, clears key, offset, mutator and key registers to zero,
// sets decrypt enable to one; both pipeline stages come up empty.
module rolling_key_xor_descrambler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // data_in[7:0]
   input  logic                          req_tuser,   // file_start
   input  logic                          req_tlast,   // file_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // data_out[7:0]
   output logic                          rsp_tlast,   // end_out
   input  logic                          csr_we,
   input  rkxd_pkg::csr_index_type       csr_index,
   input  logic [rkxd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rkxd_pkg::*;

   // configuration registers
   logic [CSR_DATA_W-1:0] key_low_ff, key_high_ff;
   logic                  enable_ff;

   // input stage
   logic       in_valid_ff;
   byte_type   in_data_ff;
   logic       in_start_ff, in_end_ff;

   // result stage
   logic       out_valid_ff;
   byte_type   out_data_ff, out_data_in;
   logic       out_end_ff;

   // descrambler state
   key_type    key_ff, key_in, key_cur;
   offset_type off_ff, off_in, off_cur;
   byte_type   mut_ff, mut_in;

   logic out_free, advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         enable_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   // start of file: reload the key and restart the block before this word
   always_comb begin
      key_cur     = in_start_ff ? key_type'({key_high_ff, key_low_ff}) : key_ff;
      off_cur     = in_start_ff ? '0 : off_ff;
      key_in      = key_cur;
      off_in      = off_cur;
      mut_in      = mut_ff;
      out_data_in = in_data_ff;
      if (enable_ff) begin
         out_data_in = in_data_ff ^ key_cur[off_cur];
         off_in      = off_cur + 1'b1;
         if (off_cur == MUTATOR_OFFSET) begin
            mut_in = out_data_in;
         end
         if (off_cur == LAST_OFFSET) begin
            key_in = evolve_key(key_cur, mut_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         key_ff       <= '0;
         off_ff       <= '0;
         mut_ff       <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            key_ff <= key_in;
            off_ff <= off_in;
            mut_ff <= mut_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff  <= req_tdata;
         in_start_ff <= req_tuser;
         in_end_ff   <= req_tlast;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_end_ff  <= in_end_ff;
      end
   end

endmodule
